// File: hw/rtl/ptd_pkg.sv
// shared types and constants for the periodic task dispatcher
// no dependencies; imported by ptd_slot_table and periodic_task_dispatcher_unit
package ptd_pkg;

  localparam int PTD_NUM_SLOTS = 8;
  localparam int RESULT_CAP    = 8;
  localparam int DISP_W        = $clog2(RESULT_CAP + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_DUE   = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  // write strobes into the slot table
  typedef struct packed {
    logic period_en;
    logic last_en;
  } tbl_wr_t;

endpackage

// File: hw/rtl/ptd_slot_table.sv
// slot table: period and last dispatch time per slot, one write and one read port
// uses ptd_pkg for the write strobe struct
module ptd_slot_table #(
  parameter int NUM_SLOTS = ptd_pkg::PTD_NUM_SLOTS,
  localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic             clk,
  input  ptd_pkg::tbl_wr_t wr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_period,
  input  logic [31:0]      wr_last,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_period_r,
  output logic [31:0]      rd_last_r
);
  import ptd_pkg::*;

  logic [31:0] period_mem [NUM_SLOTS];
  logic [31:0] last_mem   [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.period_en) begin
      period_mem[wr_addr] <= wr_period;
    end
    if (wr.last_en) begin
      last_mem[wr_addr] <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_period_r <= period_mem[rd_addr];
      rd_last_r   <= last_mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ptd_due_check.sv
// shared due test: modular elapsed time against the slot period
// no package dependencies
module ptd_due_check (
  input  logic [31:0] now_time,
  input  logic [31:0] last_time,
  input  logic [31:0] period,
  output logic        due
);

  logic [31:0] elapsed;

  // wraps modulo 2^32
  assign elapsed = now_time - last_time;
  assign due     = (elapsed >= period);

endmodule

// File: hw/rtl/periodic_task_dispatcher_unit.sv
// top level of the periodic task dispatcher: sequencer, counters and output register
// uses ptd_pkg, ptd_slot_table and ptd_due_check
//
// An add transaction gives one result (slot number, or full). A tick transaction
// advances the 32-bit time counter and walks the occupied slots one per cycle, while
// out_stall does not hold a result, through the single table read port and the single
// due checker. Each due slot gives one result in index order, at most eight per tick;
// a tick with nothing due gives one idle result. out_last marks the final result of a
// transaction. in_stall stays high until that final result has been loaded into the
// output register.
module periodic_task_dispatcher_unit #(
  parameter int NUM_SLOTS = ptd_pkg::PTD_NUM_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot_id,
  output logic [31:0] out_now_time,
  output logic        out_last
);
  import ptd_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]        time_r, time_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [DISP_W-1:0]  n_r, n_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [2:0]         out_slot_r;
  logic [31:0]        out_time_r;
  logic               out_last_r;

  logic               can_emit;
  logic               emit;
  kind_t              emit_kind;
  logic [2:0]         emit_slot;
  logic               emit_last;
  logic               scan_last;
  logic               cap_hit;
  logic               in_stall_c;

  tbl_wr_t            tbl_wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [31:0]        wr_last;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [31:0]        rd_period;
  logic [31:0]        rd_last;
  logic               due;

  ptd_slot_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_table (
    .clk        (clk),
    .wr         (tbl_wr),
    .wr_addr    (wr_addr),
    .wr_period  (in_period),
    .wr_last    (wr_last),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_period_r(rd_period),
    .rd_last_r  (rd_last)
  );

  ptd_due_check u_due (
    .now_time (time_r),
    .last_time(rd_last),
    .period   (rd_period),
    .due      (due)
  );

  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    time_nxt     = time_r;
    scan_idx_nxt = scan_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    n_nxt        = n_r;
    emit         = 1'b0;
    emit_kind    = KIND_IDLE;
    emit_slot    = 3'd0;
    emit_last    = 1'b0;
    tbl_wr       = '0;
    wr_addr      = chk_idx_r;
    wr_last      = time_r;
    rd_en        = 1'b0;
    rd_addr      = scan_idx_r[IDX_W-1:0];
    scan_last    = 1'b0;
    cap_hit      = 1'b0;
    in_stall_c   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall_c = !can_emit;
        if (in_valid && can_emit) begin
          if (in_op == OP_ADD) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            if (count_r >= CNT_W'(NUM_SLOTS)) begin
              emit_kind = KIND_FULL;
            end else begin
              emit_kind        = KIND_ADDED;
              emit_slot        = 3'(count_r);
              tbl_wr.period_en = 1'b1;
              tbl_wr.last_en   = 1'b1;
              wr_addr          = count_r[IDX_W-1:0];
              wr_last          = 32'd0;
              count_nxt        = count_r + 1'b1;
            end
          end else begin
            time_nxt     = time_r + 32'd1;
            state_nxt    = ST_SCAN;
            scan_idx_nxt = '0;
            chk_vld_nxt  = 1'b0;
            pend_vld_nxt = 1'b0;
            n_nxt        = '0;
          end
        end
      end

      ST_SCAN: begin
        if (can_emit) begin
          // read slot scan_idx while checking the slot read last step
          scan_last   = (scan_idx_r >= count_r);
          chk_vld_nxt = !scan_last;
          chk_idx_nxt = scan_idx_r[IDX_W-1:0];
          if (!scan_last) begin
            rd_en        = 1'b1;
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
          if (chk_vld_r && due) begin
            tbl_wr.last_en = 1'b1;
            wr_addr        = chk_idx_r;
            wr_last        = time_r;
            // a later due slot exists, so the held one is not the final result
            if (pend_vld_r) begin
              emit      = 1'b1;
              emit_kind = KIND_DUE;
              emit_slot = 3'(pend_idx_r);
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = chk_idx_r;
            n_nxt        = n_r + 1'b1;
            cap_hit      = (n_r == DISP_W'(RESULT_CAP - 1));
          end
          if (scan_last || cap_hit) begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (pend_vld_r) begin
            emit_kind = KIND_DUE;
            emit_slot = 3'(pend_idx_r);
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      time_r     <= time_nxt;
      scan_idx_r <= scan_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      n_r        <= n_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (emit) begin
      out_kind_r <= emit_kind;
      out_slot_r <= emit_slot;
      out_time_r <= time_r;
      out_last_r <= emit_last;
    end
  end

  assign in_stall     = in_stall_c;
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_slot_id  = out_slot_r;
  assign out_now_time = out_time_r;
  assign out_last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_SLOTS))
    else $error("slot count above table size");

  a_disp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= DISP_W'(RESULT_CAP))
    else $error("more dispatches than the result cap");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && can_emit) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("finish step did not deliver a final result");

  a_due_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_DUE && !out_last_r)
      |-> (state_r == ST_SCAN || state_r == ST_FINISH))
    else $error("non-final dispatch result with the tick already closed");

endmodule
